// ----- design/assert_macros.svh -----
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/ic8259_pkg.sv -----
// types, codes and helper functions of the interrupt controller
package ic8259_pkg;

    typedef enum logic [1:0] {
        CMD_COMMAND = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_LINE    = 2'd2,
        CMD_ACK     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ICW2  = 3'd1,
        PH_ICW3  = 3'd2,
        PH_ICW4  = 3'd3,
        PH_READY = 3'd4
    } phase_t;

    localparam logic [7:0] CMD_ICW1_BIT = 8'h10;
    localparam logic [7:0] CMD_OCW3_BIT = 8'h08;
    localparam logic [7:0] ICW1_NEED4   = 8'h01;
    localparam logic [7:0] ICW1_SINGLE  = 8'h02;
    localparam logic [7:0] ICW1_STEP4   = 8'h04;
    localparam logic [7:0] ICW1_VECHI   = 8'he0;
    localparam logic [7:0] OCW2_OPMASK  = 8'he0;
    localparam logic [7:0] OCW2_EOI     = 8'h20;
    localparam logic [7:0] OCW2_EOI_ROT = 8'ha0;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data;
        logic [2:0] line;
        logic       level;
    } item_t;

    typedef struct packed {
        logic        irq_pending;
        logic        ack_found;
        logic [15:0] vector;
        logic [7:0]  in_service;
    } result_t;

    // clear the highest-numbered set bit
    function automatic logic [7:0] clear_top(input logic [7:0] b);
        logic [7:0] hi;
        logic       seen;
        hi   = '0;
        seen = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i] && !seen)
            begin
                hi[i] = 1'b1;
                seen  = 1'b1;
            end
        end
        return b & ~hi;
    endfunction

    // index of the lowest set bit
    function automatic logic [2:0] lowest_index(input logic [7:0] b);
        logic [2:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- design/ic8259_if.sv -----
// valid/ready channel interfaces for requests and responses
interface ic8259_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data;
    logic [2:0] line;
    logic       level;

    modport source (output valid, command, data, line, level, input ready);
    modport sink   (input valid, command, data, line, level, output ready);
endinterface

interface ic8259_rsp_if;
    logic        valid;
    logic        ready;
    logic        irq_pending;
    logic        ack_found;
    logic [15:0] vector;
    logic [7:0]  in_service;

    modport source (output valid, irq_pending, ack_found, vector, in_service, input ready);
    modport sink   (input valid, irq_pending, ack_found, vector, in_service, output ready);
endinterface

// ----- design/ic8259_core.sv -----
// controller state registers and per-transaction update logic
module ic8259_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  ic8259_pkg::item_t    item,
    output ic8259_pkg::result_t  result
);
    import ic8259_pkg::*;

    logic [7:0] init_word1_reg,   init_word1_next;
    logic [7:0] vector_base_reg,  vector_base_next;
    logic [7:0] cascade_word_reg, cascade_word_next;
    logic [7:0] mode_word_reg,    mode_word_next;
    logic [7:0] op_word2_reg,     op_word2_next;
    logic [7:0] op_word3_reg,     op_word3_next;
    logic [7:0] mask_reg,         mask_next;
    logic [7:0] request_reg,      request_next;
    logic [7:0] service_reg,      service_next;
    phase_t     phase_reg,        phase_next;
    logic       irq_reg,          irq_next;

    logic [7:0]  live;
    logic [2:0]  ack_idx;
    logic [15:0] ack_offset;
    logic [15:0] ack_vector;
    logic [7:0]  line_bit;

    always_comb
    begin
        live     = request_reg & ~mask_reg;
        ack_idx  = lowest_index(live);
        line_bit = 8'(1) << item.line;
        if ((init_word1_reg & ICW1_STEP4) != '0)
        begin
            ack_offset = {11'd0, ack_idx, 2'd0};
        end
        else
        begin
            ack_offset = {10'd0, ack_idx, 3'd0};
        end
        ack_vector = {vector_base_reg, 8'd0} + {8'd0, init_word1_reg & ICW1_VECHI} + ack_offset;
    end

    always_comb
    begin
        init_word1_next   = init_word1_reg;
        vector_base_next  = vector_base_reg;
        cascade_word_next = cascade_word_reg;
        mode_word_next    = mode_word_reg;
        op_word2_next     = op_word2_reg;
        op_word3_next     = op_word3_reg;
        mask_next         = mask_reg;
        request_next      = request_reg;
        service_next      = service_reg;
        phase_next        = phase_reg;
        irq_next          = irq_reg;
        result.ack_found  = 1'b0;
        result.vector     = '0;

        unique case (cmd_t'(item.command))
            CMD_COMMAND:
            begin
                if ((item.data & CMD_ICW1_BIT) != '0)
                begin
                    init_word1_next = item.data;
                    phase_next      = PH_ICW2;
                end
                else if ((item.data & CMD_OCW3_BIT) != '0)
                begin
                    op_word3_next = item.data;
                end
                else
                begin
                    op_word2_next = item.data;
                    if ((item.data & OCW2_OPMASK) == OCW2_EOI
                        || (item.data & OCW2_OPMASK) == OCW2_EOI_ROT)
                    begin
                        service_next = clear_top(service_reg);
                    end
                end
            end
            CMD_DATA:
            begin
                unique case (phase_reg)
                    PH_ICW2:
                    begin
                        vector_base_next = item.data;
                        if ((init_word1_reg & ICW1_SINGLE) == '0)
                        begin
                            phase_next = PH_ICW3;
                        end
                        else if ((init_word1_reg & ICW1_NEED4) != '0)
                        begin
                            phase_next = PH_ICW4;
                        end
                        else
                        begin
                            phase_next = PH_READY;
                        end
                    end
                    PH_ICW3:
                    begin
                        cascade_word_next = item.data;
                        phase_next = ((init_word1_reg & ICW1_NEED4) != '0) ? PH_ICW4 : PH_READY;
                    end
                    PH_ICW4:
                    begin
                        mode_word_next = item.data;
                        phase_next     = PH_READY;
                    end
                    PH_READY:
                    begin
                        mask_next = item.data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_LINE:
            begin
                if (item.level)
                begin
                    request_next = request_reg | line_bit;
                end
                else
                begin
                    request_next = request_reg & ~line_bit;
                end
                irq_next = |(request_next & ~mask_reg);
            end
            CMD_ACK:
            begin
                if (live != '0)
                begin
                    service_next     = service_reg | (8'(1) << ack_idx);
                    result.ack_found = 1'b1;
                    result.vector    = ack_vector;
                end
            end
            default:
            begin
            end
        endcase

        result.irq_pending = irq_next;
        result.in_service  = service_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_word1_reg   <= '0;
            vector_base_reg  <= '0;
            cascade_word_reg <= '0;
            mode_word_reg    <= '0;
            op_word2_reg     <= '0;
            op_word3_reg     <= '0;
            mask_reg         <= '0;
            request_reg      <= '0;
            service_reg      <= '0;
            phase_reg        <= PH_IDLE;
            irq_reg          <= 1'b0;
        end
        else if (step)
        begin
            init_word1_reg   <= init_word1_next;
            vector_base_reg  <= vector_base_next;
            cascade_word_reg <= cascade_word_next;
            mode_word_reg    <= mode_word_next;
            op_word2_reg     <= op_word2_next;
            op_word3_reg     <= op_word3_next;
            mask_reg         <= mask_next;
            request_reg      <= request_next;
            service_reg      <= service_next;
            phase_reg        <= phase_next;
            irq_reg          <= irq_next;
        end
    end

endmodule

// ----- design/interrupt_controller_8259.sv -----
// top level of the 8259-style interrupt controller
//
//   channel  direction  payload
//   req      in         command, data, line, level
//   rsp      out        irq_pending, ack_found, vector, in_service
//
// one transaction per cycle sustained while rsp is ready; each passes the input register, then the result register
// the input register feeds one pass of priority and update logic into the result register
// req stays ready while the result register drains or a result waits with the input stage empty
// rst_n clears all controller state to zero and empties both stages
module interrupt_controller_8259 (
    input  logic  clk,
    input  logic  rst_n,
    ic8259_req_if.sink   req,
    ic8259_rsp_if.source rsp
);
    import ic8259_pkg::*;

    `include "assert_macros.svh"

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= '{command: req.command, data: req.data, line: req.line,
                          level: req.level};
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    ic8259_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result_next)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.irq_pending = result_reg.irq_pending;
    assign rsp.ack_found   = result_reg.ack_found;
    assign rsp.vector      = result_reg.vector;
    assign rsp.in_service  = result_reg.in_service;

    `ASSERT_IMPLIES(a_ack_in_service, clk, rst_n, rsp.valid && rsp.ack_found, rsp.in_service != 8'd0)
    `ASSERT_IMPLIES(a_vector_only_ack, clk, rst_n, rsp.valid && !rsp.ack_found, rsp.vector == 16'd0)
    `ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the 8259-style interrupt controller
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ic8259_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    class pic_tracker;
        logic [7:0] icw1;
        logic [7:0] base;
        logic [7:0] icw3;
        logic [7:0] icw4;
        logic [7:0] ocw2;
        logic [7:0] ocw3;
        logic [7:0] imr;
        logic [7:0] irr;
        logic [7:0] isr;
        phase_t     phase;
        logic       irq;
        result_t    pending[$];
        int         errors;

        function new();
            icw1   = '0;
            base   = '0;
            icw3   = '0;
            icw4   = '0;
            ocw2   = '0;
            ocw3   = '0;
            imr    = '0;
            irr    = '0;
            isr    = '0;
            phase  = PH_IDLE;
            irq    = 1'b0;
            errors = 0;
        endfunction

        function void note_request(item_t it);
            result_t    r;
            logic [7:0] live;
            logic [7:0] op;
            int         stride;
            r = '0;
            case (cmd_t'(it.command))
                CMD_COMMAND:
                begin
                    op = it.data & OCW2_OPMASK;
                    if ((it.data & CMD_ICW1_BIT) != 0)
                    begin
                        icw1  = it.data;
                        phase = PH_ICW2;
                    end
                    else if ((it.data & CMD_OCW3_BIT) != 0)
                    begin
                        ocw3 = it.data;
                    end
                    else
                    begin
                        ocw2 = it.data;
                        if (op == OCW2_EOI || op == OCW2_EOI_ROT)
                        begin
                            for (int i = 7; i >= 0; i--)
                            begin
                                if (isr[i])
                                begin
                                    isr[i] = 1'b0;
                                    break;
                                end
                            end
                        end
                    end
                end
                CMD_DATA:
                begin
                    case (phase)
                        PH_ICW2:
                        begin
                            base = it.data;
                            if ((icw1 & ICW1_SINGLE) == 0)
                                phase = PH_ICW3;
                            else if ((icw1 & ICW1_NEED4) != 0)
                                phase = PH_ICW4;
                            else
                                phase = PH_READY;
                        end
                        PH_ICW3:
                        begin
                            icw3  = it.data;
                            phase = ((icw1 & ICW1_NEED4) != 0) ? PH_ICW4 : PH_READY;
                        end
                        PH_ICW4:
                        begin
                            icw4  = it.data;
                            phase = PH_READY;
                        end
                        PH_READY:
                        begin
                            imr = it.data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_LINE:
                begin
                    irr[it.line] = it.level;
                    irq = |(irr & ~imr);
                end
                default:
                begin
                    live   = irr & ~imr;
                    stride = ((icw1 & ICW1_STEP4) != 0) ? 4 : 8;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (live[i])
                        begin
                            isr[i]      = 1'b1;
                            r.ack_found = 1'b1;
                            r.vector    = 16'(({base, 8'h00}) + (icw1 & ICW1_VECHI) + i * stride);
                            break;
                        end
                    end
                end
            endcase
            r.irq_pending = irq;
            r.in_service  = isr;
            pending.push_back(r);
        endfunction

        function void check_response(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("response transaction with nothing outstanding: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.irq_pending !== want.irq_pending)
            begin
                $error("irq_pending expected %0d actual %0d", want.irq_pending, got.irq_pending);
                errors++;
            end
            if (got.ack_found !== want.ack_found)
            begin
                $error("ack_found expected %0d actual %0d", want.ack_found, got.ack_found);
                errors++;
            end
            if (got.vector !== want.vector)
            begin
                $error("vector expected %h actual %h", want.vector, got.vector);
                errors++;
            end
            if (got.in_service !== want.in_service)
            begin
                $error("in_service expected %h actual %h", want.in_service, got.in_service);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic quiet;
    logic hold_due;
    logic hold_armed;
    int   cycles;
    int   sent;

    pic_tracker tracker = new();

    ic8259_req_if req_if ();
    ic8259_rsp_if rsp_if ();

    interrupt_controller_8259 DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            tracker.check_response({rsp_if.irq_pending, rsp_if.ack_found,
                                    rsp_if.vector, rsp_if.in_service});
        end
    end

    // response side: random stalls, one long hold-off, always ready when quiet
    initial
    begin
        rsp_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_due)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_due = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                rsp_if.ready <= 1'b1;
                @(negedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    task automatic send_item(input cmd_t cmd, input logic [7:0] d,
                             input logic [2:0] ln, input logic lv);
        item_t it;
        int    gap;
        it.command = cmd;
        it.data    = d;
        it.line    = ln;
        it.level   = lv;
        gap = (quiet || $urandom_range(0, 5) != 0) ? 0 : $urandom_range(1, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= it.command;
        req_if.data    <= it.data;
        req_if.line    <= it.line;
        req_if.level   <= it.level;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        tracker.note_request(it);
        sent++;
    endtask

    task automatic random_session();
        logic [7:0] icw1;
        logic [7:0] d;
        int         ops;
        int         pick;
        int         cut;
        icw1 = 8'($urandom_range(0, 255)) | CMD_ICW1_BIT;
        cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 4;
        send_item(CMD_COMMAND, icw1, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        if (cut > 1)
            send_item(CMD_DATA, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b0);
        if (cut > 2 && (icw1 & ICW1_SINGLE) == 0)
            send_item(CMD_DATA, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b1);
        if (cut > 3 && (icw1 & ICW1_NEED4) != 0)
            send_item(CMD_DATA, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b0);
        if (cut > 3)
            send_item(CMD_DATA, 8'($urandom_range(0, 255) & $urandom_range(0, 255)),
                      3'($urandom_range(0, 7)), 1'b1);
        ops = $urandom_range(10, 40);
        repeat (ops)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_item(CMD_LINE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 4) != 0));
            end
            else if (pick < 60)
            begin
                send_item(CMD_ACK, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            end
            else if (pick < 72)
            begin
                d = ($urandom_range(0, 1) != 0) ? OCW2_EOI : OCW2_EOI_ROT;
                send_item(CMD_COMMAND, d | 8'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            end
            else if (pick < 77)
            begin
                send_item(CMD_COMMAND, 8'($urandom_range(0, 255)) & 8'he7,
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 82)
            begin
                d = (8'($urandom_range(0, 255)) & 8'he7) | CMD_OCW3_BIT;
                send_item(CMD_COMMAND, d, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 92)
            begin
                d = ($urandom_range(0, 3) == 0) ? 8'h00
                    : 8'($urandom_range(0, 255) & $urandom_range(0, 255));
                send_item(CMD_DATA, d, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        quiet          = 1'b0;
        hold_due       = 1'b0;
        hold_armed     = 1'b1;
        cycles         = 0;
        sent           = 0;
        req_if.valid   = 1'b0;
        req_if.command = CMD_COMMAND;
        req_if.data    = '0;
        req_if.line    = '0;
        req_if.level   = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // before initialization: empty ack, ignored data write, ack on raw state
        send_item(CMD_ACK, 8'h00, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'ha5, 3'd0, 1'b0);
        send_item(CMD_LINE, 8'h00, 3'd0, 1'b1);
        send_item(CMD_ACK, 8'hff, 3'd7, 1'b1);
        send_item(CMD_COMMAND, OCW2_EOI, 3'd0, 1'b0);
        send_item(CMD_COMMAND, OCW2_EOI, 3'd0, 1'b0);
        // single mode with icw4, interval 8, vector wraps past the top
        send_item(CMD_COMMAND, 8'hfb, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'hff, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'h00, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'h00, 3'd0, 1'b0);
        send_item(CMD_LINE, 8'h00, 3'd7, 1'b1);
        send_item(CMD_ACK, 8'h00, 3'd0, 1'b0);
        send_item(CMD_LINE, 8'h00, 3'd0, 1'b0);
        send_item(CMD_ACK, 8'h00, 3'd0, 1'b0);
        // mask leaves irq alone, fully masked ack finds nothing
        send_item(CMD_DATA, 8'hff, 3'd0, 1'b0);
        send_item(CMD_ACK, 8'h00, 3'd0, 1'b0);
        send_item(CMD_COMMAND, OCW2_EOI_ROT, 3'd0, 1'b0);
        send_item(CMD_COMMAND, 8'h0b, 3'd0, 1'b0);
        send_item(CMD_COMMAND, 8'h60, 3'd0, 1'b0);
        // cascade without icw4, interval 4
        send_item(CMD_COMMAND, 8'h14, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'h12, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'h34, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'h00, 3'd0, 1'b0);
        // single mode without icw4 finishes after icw2
        send_item(CMD_COMMAND, 8'h12, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'h80, 3'd0, 1'b0);
        send_item(CMD_DATA, 8'h7f, 3'd0, 1'b0);
        send_item(CMD_ACK, 8'h00, 3'd0, 1'b0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (hold_armed && sent >= HOLD_AFTER)
            begin
                hold_due   = 1'b1;
                hold_armed = 1'b0;
            end
            if (sent >= RANDOM_ITEMS - 120)
                quiet = 1'b1;
            random_session();
        end
        @(negedge clk);
        req_if.valid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
